/* hdl/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);

   // Request command codes
   typedef enum logic [2:0] {
      KIND_START    = 3'd0,
      KIND_STOP     = 3'd1,
      KIND_WR_BYTE  = 3'd2,
      KIND_RD_BYTE  = 3'd3,
      KIND_SEND_ACK = 3'd4,
      KIND_RD_ACK   = 3'd5
   } kind_type;

   // Execution classes seen by the back end
   typedef enum logic [1:0] {
      OP_START,
      OP_STOP,
      OP_XFER
   } op_type;

   // Pin-write phase inside one bit slot
   typedef enum logic [1:0] {
      PH_SDA   = 2'd0,
      PH_SCL_H = 2'd1,
      PH_SCL_L = 2'd2,
      PH_EXTRA = 2'd3
   } phase_type;

   // Decoded command handed from front to back
   typedef struct packed {
      op_type                   op;
      logic [BITS_PER_BYTE-1:0] data;        // SDA bits driven MSB first
      logic                     is_read;     // SDA written only in first slot
      logic                     single;      // one bit slot instead of a byte
      logic [BITS_PER_BYTE-1:0] read_value;  // reported on the final beat
   } cmd_type;

   // Queue status toward the front
   typedef struct packed {
      logic full;
   } q_stat_type;

endpackage

/* hdl/i2cms_channels.sv */
// ----------------------------------------------------------------------------
// i2cms channel interfaces
// Valid/ready channels for command requests and pin-write responses.
// ----------------------------------------------------------------------------
interface i2cms_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] tx_byte;
   logic       ack_bit;
   logic [7:0] sda_levels;

   modport source (output valid, kind, tx_byte, ack_bit, sda_levels, input ready);
   modport sink   (input valid, kind, tx_byte, ack_bit, sda_levels, output ready);
endinterface

interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic [7:0] read_value;
   logic       last;

   modport source (output valid, scl_out, sda_out, read_value, last, input ready);
   modport sink   (input valid, scl_out, sda_out, read_value, last, output ready);
endinterface

/* hdl/i2cms_front.sv */
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts request beats and decodes each into a back-end command.
// ----------------------------------------------------------------------------
module i2cms_front
   import i2cms_pkg::*;
(
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_ack_bit,
   input  logic [7:0]  req_sda_levels,
   input  q_stat_type  q_stat,
   output logic        push,
   output cmd_type     push_cmd
);

   logic known;

   // Stall only on a full queue
   assign req_ready = ~q_stat.full;

   // Decode the command; unused codes are dropped
   always_comb begin
      known               = 1'b1;
      push_cmd.op         = OP_XFER;
      push_cmd.data       = '1;
      push_cmd.is_read    = 1'b0;
      push_cmd.single     = 1'b0;
      push_cmd.read_value = '0;
      unique case (req_kind)
         KIND_START: begin
            push_cmd.op = OP_START;
         end
         KIND_STOP: begin
            push_cmd.op = OP_STOP;
         end
         KIND_WR_BYTE: begin
            push_cmd.data = req_tx_byte;
         end
         KIND_RD_BYTE: begin
            push_cmd.is_read    = 1'b1;
            push_cmd.read_value = req_sda_levels;
         end
         KIND_SEND_ACK: begin
            push_cmd.single = 1'b1;
            push_cmd.data   = {req_ack_bit, {(BITS_PER_BYTE-1){1'b0}}};
         end
         KIND_RD_ACK: begin
            push_cmd.single     = 1'b1;
            push_cmd.is_read    = 1'b1;
            push_cmd.read_value = {{(BITS_PER_BYTE-1){1'b0}},
                                   req_sda_levels[BITS_PER_BYTE-1]};
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign push = req_valid & req_ready & known;

endmodule

/* hdl/i2cms_queue.sv */
// ----------------------------------------------------------------------------
// i2cms_queue
// Short command FIFO between the decode front and the pin sequencer.
// ----------------------------------------------------------------------------
module i2cms_queue
   import i2cms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmd_type    push_cmd,
   input  logic       pop,
   output q_stat_type q_stat,
   output logic       head_valid,
   output cmd_type    head_cmd
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign q_stat.full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid  = (count_ff != '0);
   assign head_cmd    = slot_ff[rd_ptr_ff];

endmodule

/* hdl/i2cms_back.sv */
// ----------------------------------------------------------------------------
// i2cms_back
// Steps through the head command's pin writes, one beat per unstalled cycle.
// ----------------------------------------------------------------------------
module i2cms_back
   import i2cms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_out,
   output logic       rsp_sda_out,
   output logic [7:0] rsp_read_value,
   output logic       rsp_last
);

   phase_type               phase_ff, phase_in;
   logic [BIT_IDX_W-1:0]    bit_ff, bit_in;
   logic                    scl_ff, scl_in;
   logic                    sda_ff, sda_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_scl_ff, out_sda_ff, out_last_ff;
   logic [7:0]              out_value_ff;
   logic                    adv;
   logic                    step_last;

   // Advance when a command waits and the output register is free
   assign adv = head_valid & (~rsp_valid_ff | rsp_ready);
   assign pop = adv & step_last;

   // Pin write of the current step
   always_comb begin
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      step_last = 1'b0;
      unique case (head_cmd.op)
         OP_START: begin
            unique case (phase_ff)
               PH_SDA:   sda_in = 1'b1;
               PH_SCL_H: scl_in = 1'b1;
               PH_SCL_L: sda_in = 1'b0;
               PH_EXTRA: begin
                  scl_in    = 1'b0;
                  step_last = 1'b1;
               end
               default: ;
            endcase
         end
         OP_STOP: begin
            unique case (phase_ff)
               PH_SDA:   sda_in = 1'b0;
               PH_SCL_H: scl_in = 1'b1;
               default: begin
                  sda_in    = 1'b1;
                  step_last = 1'b1;
               end
            endcase
         end
         default: begin
            // Bit slot: drive SDA (reads: first slot only), raise SCL, drop SCL
            unique case (phase_ff)
               PH_SDA:   sda_in = head_cmd.data[~bit_ff];
               PH_SCL_H: scl_in = 1'b1;
               default: begin
                  scl_in    = 1'b0;
                  step_last = head_cmd.single |
                              (bit_ff == BIT_IDX_W'(BITS_PER_BYTE-1));
               end
            endcase
         end
      endcase
   end

   // Step counters
   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      if (adv) begin
         if (step_last) begin
            phase_in = PH_SDA;
            bit_in   = '0;
         end else if (head_cmd.op == OP_XFER && phase_ff == PH_SCL_L) begin
            phase_in = head_cmd.is_read ? PH_SCL_H : PH_SDA;
            bit_in   = bit_ff + 1'b1;
         end else begin
            phase_in = phase_type'(phase_ff + 2'd1);
         end
      end
   end

   // Output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SDA;
         bit_ff       <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            scl_ff <= scl_in;
            sda_ff <= sda_in;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (adv) begin
         out_scl_ff   <= scl_in;
         out_sda_ff   <= sda_in;
         out_last_ff  <= step_last;
         out_value_ff <= step_last ? head_cmd.read_value : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_out    = out_scl_ff;
   assign rsp_sda_out    = out_sda_ff;
   assign rsp_read_value = out_value_ff;
   assign rsp_last       = out_last_ff;

endmodule

/* hdl/i2c_master_bit_sequencer_core.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// I2C master command sequencer emitting one response beat per pin write.
// ----------------------------------------------------------------------------
// Each request beat is one bus command (start, stop, write byte, read byte,
// send ack, read ack); the core answers with one response beat per SCL/SDA
// write, flagging the final beat of the command and carrying the sampled
// byte or ack bit there for reads. Unused command codes are accepted and
// produce nothing. The pin sequencer issues one response beat per cycle while
// the response output is not held; a command has 3 pin writes for stop and
// the ack commands, 4 for start, 17 for read byte and 24 for write byte.
// A two-entry command queue decouples request intake from the sequencer, and
// the response output register takes the next beat in the same cycle that the
// current one is accepted. Both pins come out of reset high.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core
   import i2cms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   i2cms_req_if.sink    req_chan,
   i2cms_rsp_if.source  rsp_chan
);

   q_stat_type q_stat;
   logic       push;
   cmd_type    push_cmd;
   logic       pop;
   logic       head_valid;
   cmd_type    head_cmd;

   // Request decode
   i2cms_front u_front (
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_kind       (req_chan.kind),
      .req_tx_byte    (req_chan.tx_byte),
      .req_ack_bit    (req_chan.ack_bit),
      .req_sda_levels (req_chan.sda_levels),
      .q_stat         (q_stat),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // Command queue
   i2cms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .q_stat     (q_stat),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Pin sequencer
   i2cms_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_scl_out    (rsp_chan.scl_out),
      .rsp_sda_out    (rsp_chan.sda_out),
      .rsp_read_value (rsp_chan.read_value),
      .rsp_last       (rsp_chan.last)
   );

endmodule
